>>> design/oeaf_pkg.sv
// Shared widths and request/response types for the One Euro filter datapath units.
package oeaf_pkg;

	// Fraction bits of the smoothing factor alpha; alpha spans 0 .. 1.0 inclusive.
	localparam int ALPHA_FRAC = 16;
	localparam int ALPHA_W    = ALPHA_FRAC + 1;

	// Shared multiplier: wide operand taken in two 32-bit halves.
	localparam int MUL_B_W = 32;
	localparam int MUL_A_W = 2 * MUL_B_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Angular cutoff w = 2*pi*fc, its divisor w + rate, and the dividend w << ALPHA_FRAC.
	localparam int W_W        = 35;
	localparam int DEN_W      = W_W + 1;
	localparam int DIVIDEND_W = W_W + ALPHA_FRAC;
	localparam int DIV_CNT_W  = $clog2(ALPHA_W + 1);

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DEN_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [ALPHA_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> design/oeaf_mul.sv
// Shared 64x32 multiplier built from one 32x32 multiplier over two partial products.
module oeaf_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  oeaf_pkg::mul_req_t req,
	output oeaf_pkg::mul_rsp_t rsp
);

	localparam int HALF_W = oeaf_pkg::MUL_B_W;

	typedef enum logic [1:0] {
		M_IDLE,
		M_LO,
		M_HI,
		M_ACC
	} phase_t;

	phase_t                          phase_q;
	logic                            done_q;
	logic [oeaf_pkg::MUL_A_W-1:0]    a_q;
	logic [oeaf_pkg::MUL_B_W-1:0]    b_q;
	logic [2*HALF_W-1:0]             pp_q;
	logic [oeaf_pkg::PROD_W-1:0]     acc_q;
	logic [HALF_W-1:0]               mul_lhs;
	logic [2*HALF_W-1:0]             pp;

	// One multiplier; the low half of a goes first, then the high half.
	always_comb begin
		mul_lhs = (phase_q == M_LO) ? a_q[HALF_W-1:0] : a_q[2*HALF_W-1:HALF_W];
		pp      = mul_lhs * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= M_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			pp_q    <= '0;
			acc_q   <= '0;
		end else begin
			// Pulse done with the last accumulate.
			done_q <= (phase_q == M_ACC);
			unique case (phase_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						phase_q <= M_LO;
					end
				end
				M_LO: begin
					pp_q    <= pp;
					phase_q <= M_HI;
				end
				M_HI: begin
					acc_q   <= {{(oeaf_pkg::PROD_W-2*HALF_W){1'b0}}, pp_q};
					pp_q    <= pp;
					phase_q <= M_ACC;
				end
				M_ACC: begin
					acc_q   <= acc_q + {pp_q, {HALF_W{1'b0}}};
					phase_q <= M_IDLE;
				end
				default: phase_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

>>> design/oeaf_div.sv
// Restoring divider for the smoothing factor: one quotient bit per cycle.
module oeaf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  oeaf_pkg::div_req_t req,
	output oeaf_pkg::div_rsp_t rsp
);

	localparam int QW     = oeaf_pkg::ALPHA_W;
	localparam int DEN_W  = oeaf_pkg::DEN_W;
	localparam int HEAD_W = oeaf_pkg::DIVIDEND_W - QW;

	logic                           busy_q;
	logic                           done_q;
	logic [oeaf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]               rem_q;
	logic [DEN_W-1:0]               dsr_q;
	logic [QW-1:0]                  bits_q;
	logic [QW-1:0]                  quot_q;
	logic [DEN_W:0]                 trial;
	logic [DEN_W:0]                 diff;
	logic                           q_bit;
	logic [DEN_W-1:0]               rem_next;
	logic                           last_step;

	// The quotient fits in QW bits, so the head of the dividend is already below the divisor.
	always_comb begin
		trial     = {rem_q, bits_q[QW-1]};
		diff      = trial - {1'b0, dsr_q};
		q_bit     = (trial >= {1'b0, dsr_q});
		rem_next  = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		last_step = busy_q && !req.start && (cnt_q == oeaf_pkg::DIV_CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			bits_q <= '0;
			quot_q <= '0;
		end else begin
			done_q <= last_step;
			if (req.start) begin
				rem_q  <= {{(DEN_W-HEAD_W){1'b0}}, req.dividend[oeaf_pkg::DIVIDEND_W-1:QW]};
				bits_q <= req.dividend[QW-1:0];
				dsr_q  <= req.divisor;
				cnt_q  <= oeaf_pkg::DIV_CNT_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= rem_next;
				bits_q <= {bits_q[QW-2:0], 1'b0};
				quot_q <= {quot_q[QW-2:0], q_bit};
				cnt_q  <= cnt_q - 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> design/one_euro_adaptive_filter.sv
// One Euro adaptive filter top level: config registers, sequencer and filter state.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------------
//  input     in         in_valid / in_stall     sample_in  (signed Q16.16 by default)
//  output    out        out_valid / out_stall   sample_out (signed Q16.16 by default)
//  config    in         cfg_we (write only)     cfg_index, cfg_data (32 bits)
//
// A primed sample runs from accept to result through six 64x32 products on the shared 32x32
// multiplier (issue states S_SL, S_CUT and S_VAL among them), two alpha divisions and S_OUT,
// which waits while the output register is full and stalled, then loads it and returns to S_IDLE.
// A zero divisor skips its division; the first sample after reset only primes and goes straight
// to S_OUT. Reset (arst_n low) restores the register defaults and clears the primed flag.
// in_stall is high while a sample is in work; a finished result waits in the output register.
module one_euro_adaptive_filter #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int REG_W       = 32;
	localparam int SW          = SAMPLE_WIDTH;
	localparam int DIFF_W      = SAMPLE_WIDTH + 1;
	localparam int SLOPE_W     = 48;
	localparam int SD_W        = SLOPE_W + 1;
	localparam int MAG_W       = SLOPE_W - 1;
	localparam int TWO_PI_FRAC = 28;
	localparam int AF          = oeaf_pkg::ALPHA_FRAC;
	localparam int AW          = oeaf_pkg::ALPHA_W;
	localparam int PW          = oeaf_pkg::PROD_W;
	localparam int MAW         = oeaf_pkg::MUL_A_W;
	localparam int MBW         = oeaf_pkg::MUL_B_W;
	localparam int WW          = oeaf_pkg::W_W;
	localparam int DW          = oeaf_pkg::DEN_W;

	localparam logic [MBW-1:0]   TWO_PI_Q28 = 32'd1686629713;
	localparam logic [MAG_W-1:0] SLOPE_MAX  = {MAG_W{1'b1}};
	localparam logic [AW-1:0]    ALPHA_ONE  = {1'b1, {AF{1'b0}}};

	// Register indexes and reset values.
	localparam logic [2:0]       CFG_SAMPLE_RATE  = 3'd0;
	localparam logic [2:0]       CFG_MIN_CUTOFF   = 3'd1;
	localparam logic [2:0]       CFG_BETA_GAIN    = 3'd2;
	localparam logic [2:0]       CFG_DERIV_CUTOFF = 3'd3;
	localparam logic [REG_W-1:0] RATE_RESET       = 32'd3932160;
	localparam logic [REG_W-1:0] MIN_CUT_RESET    = 32'd65536;
	localparam logic [REG_W-1:0] BETA_RESET       = 32'd0;
	localparam logic [REG_W-1:0] DCUT_RESET       = 32'd65536;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DX_W,    // derivative product in flight
		S_WD_W,    // 2*pi*deriv_cutoff in flight
		S_AD_W,    // derivative alpha division in flight
		S_SL,      // issue slope smoothing product
		S_SL_W,
		S_CUT,     // issue beta * |slope|
		S_CUT_W,
		S_WC_W,    // 2*pi*cutoff in flight
		S_AC_W,    // sample alpha division in flight
		S_VAL,     // issue value smoothing product
		S_VAL_W,
		S_OUT
	} state_t;

	state_t                state_q;
	logic                  primed_q;
	logic                  out_valid_q;
	logic signed [SW-1:0]  sample_out_q;
	logic [SW-1:0]         x_q;
	logic [SW-1:0]         value_q;
	logic [SLOPE_W-1:0]    slope_q;
	logic [MAG_W-1:0]      dx_mag_q;
	logic                  neg_q;
	logic [AW-1:0]         alpha_q;

	logic [REG_W-1:0]      rate_q;
	logic [REG_W-1:0]      min_cut_q;
	logic [REG_W-1:0]      beta_q;
	logic [REG_W-1:0]      dcut_q;

	oeaf_pkg::mul_req_t    mul_req;
	oeaf_pkg::mul_rsp_t    mul_rsp;
	oeaf_pkg::div_req_t    div_req;
	oeaf_pkg::div_rsp_t    div_rsp;

	logic [SW-1:0]         diff_src;
	logic [DIFF_W-1:0]     diff_w;
	logic                  diff_neg;
	logic [DIFF_W-1:0]     diff_mag;
	logic [MAG_W-1:0]      dx_mag;
	logic [SLOPE_W-1:0]    dx_s;
	logic [SD_W-1:0]       sd_w;
	logic                  sd_neg;
	logic [SD_W-1:0]       sd_mag;
	logic [SLOPE_W-1:0]    slope_step;
	logic [SLOPE_W-1:0]    slope_new;
	logic [SLOPE_W-1:0]    slope_mag;
	logic                  cut_hi_nz;
	logic [REG_W:0]        cut_sum;
	logic [REG_W-1:0]      cutoff;
	logic [WW-1:0]         w_val;
	logic [DW-1:0]         den;
	logic                  den_zero;
	logic [DIFF_W-1:0]     val_step;
	logic [SW-1:0]         val_new;

	oeaf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	oeaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_RESET;
			min_cut_q <= MIN_CUT_RESET;
			beta_q    <= BETA_RESET;
			dcut_q    <= DCUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_RATE:  rate_q    <= cfg_data;
				CFG_MIN_CUTOFF:   min_cut_q <= cfg_data;
				CFG_BETA_GAIN:    beta_q    <= cfg_data;
				CFG_DERIV_CUTOFF: dcut_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath glue around the shared units. Magnitudes feed the multiplier, signs are
	// reapplied afterward, so every product is unsigned and truncation is toward zero.
	always_comb begin
		// Sample minus estimate: the new sample at accept, the held sample later on.
		diff_src = (state_q == S_IDLE) ? sample_in : x_q;
		diff_w   = {diff_src[SW-1], diff_src} - {value_q[SW-1], value_q};
		diff_neg = diff_w[DIFF_W-1];
		diff_mag = diff_neg ? (~diff_w + 1'b1) : diff_w;

		// Derivative magnitude, saturated to 2^47 - 1.
		dx_mag = (|mul_rsp.prod[PW-1:FRAC_BITS+MAG_W]) ? SLOPE_MAX
			: mul_rsp.prod[FRAC_BITS+MAG_W-1:FRAC_BITS];

		// Slope smoother: signed derivative minus slope estimate.
		dx_s       = neg_q ? (~{1'b0, dx_mag_q} + 1'b1) : {1'b0, dx_mag_q};
		sd_w       = {dx_s[SLOPE_W-1], dx_s} - {slope_q[SLOPE_W-1], slope_q};
		sd_neg     = sd_w[SD_W-1];
		sd_mag     = sd_neg ? (~sd_w + 1'b1) : sd_w;
		slope_step = mul_rsp.prod[AF+SLOPE_W-1:AF];
		slope_new  = neg_q ? (slope_q - slope_step) : (slope_q + slope_step);
		slope_mag  = slope_q[SLOPE_W-1] ? (~slope_q + 1'b1) : slope_q;

		// Cutoff = min_cutoff + beta*|slope|, saturated to the register range.
		cut_hi_nz = |mul_rsp.prod[PW-1:FRAC_BITS+REG_W];
		cut_sum   = {1'b0, min_cut_q} + {1'b0, mul_rsp.prod[FRAC_BITS+REG_W-1:FRAC_BITS]};
		cutoff    = (cut_hi_nz || cut_sum[REG_W]) ? {REG_W{1'b1}} : cut_sum[REG_W-1:0];

		// w = 2*pi*fc and the alpha divisor w + rate.
		w_val    = mul_rsp.prod[TWO_PI_FRAC+WW-1:TWO_PI_FRAC];
		den      = {1'b0, w_val} + {{(DW-REG_W){1'b0}}, rate_q};
		den_zero = (den == '0);

		// Value smoother step; the result stays between estimate and sample.
		val_step = mul_rsp.prod[AF+DIFF_W-1:AF];
		val_new  = neg_q ? (value_q - val_step[SW-1:0]) : (value_q + val_step[SW-1:0]);

		mul_req = '0;
		div_req = '0;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid && primed_q) begin
					mul_req.start = 1'b1;
					mul_req.a     = {{(MAW-DIFF_W){1'b0}}, diff_mag};
					mul_req.b     = rate_q;
				end
			end
			S_DX_W: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = {{(MAW-REG_W){1'b0}}, dcut_q};
					mul_req.b     = TWO_PI_Q28;
				end
			end
			S_WD_W, S_WC_W: begin
				if (mul_rsp.done && !den_zero) begin
					div_req.start    = 1'b1;
					div_req.dividend = {w_val, {AF{1'b0}}};
					div_req.divisor  = den;
				end
			end
			S_SL: begin
				mul_req.start = 1'b1;
				mul_req.a     = {{(MAW-SD_W){1'b0}}, sd_mag};
				mul_req.b     = {{(MBW-AW){1'b0}}, alpha_q};
			end
			S_CUT: begin
				mul_req.start = 1'b1;
				mul_req.a     = {{(MAW-SLOPE_W){1'b0}}, slope_mag};
				mul_req.b     = beta_q;
			end
			S_CUT_W: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = {{(MAW-REG_W){1'b0}}, cutoff};
					mul_req.b     = TWO_PI_Q28;
				end
			end
			S_VAL: begin
				mul_req.start = 1'b1;
				mul_req.a     = {{(MAW-DIFF_W){1'b0}}, diff_mag};
				mul_req.b     = {{(MBW-AW){1'b0}}, alpha_q};
			end
			default: ;
		endcase
	end

	// Sequencer, filter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			x_q          <= '0;
			value_q      <= '0;
			slope_q      <= '0;
			dx_mag_q     <= '0;
			neg_q        <= 1'b0;
			alpha_q      <= '0;
		end else begin
			// Drop the result once the transaction completes; S_OUT reloads it itself.
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q <= sample_in;
						if (!primed_q) begin
							// First sample passes through; slope starts at zero.
							primed_q <= 1'b1;
							value_q  <= sample_in;
							slope_q  <= '0;
							state_q  <= S_OUT;
						end else begin
							neg_q   <= diff_neg;
							state_q <= S_DX_W;
						end
					end
				end
				S_DX_W: begin
					if (mul_rsp.done) begin
						dx_mag_q <= dx_mag;
						state_q  <= S_WD_W;
					end
				end
				S_WD_W: begin
					if (mul_rsp.done) begin
						if (den_zero) begin
							alpha_q <= ALPHA_ONE;
							state_q <= S_SL;
						end else begin
							state_q <= S_AD_W;
						end
					end
				end
				S_AD_W: begin
					if (div_rsp.done) begin
						alpha_q <= div_rsp.quot;
						state_q <= S_SL;
					end
				end
				S_SL: begin
					neg_q   <= sd_neg;
					state_q <= S_SL_W;
				end
				S_SL_W: begin
					if (mul_rsp.done) begin
						slope_q <= slope_new;
						state_q <= S_CUT;
					end
				end
				S_CUT: begin
					state_q <= S_CUT_W;
				end
				S_CUT_W: begin
					if (mul_rsp.done) begin
						state_q <= S_WC_W;
					end
				end
				S_WC_W: begin
					if (mul_rsp.done) begin
						if (den_zero) begin
							alpha_q <= ALPHA_ONE;
							state_q <= S_VAL;
						end else begin
							state_q <= S_AC_W;
						end
					end
				end
				S_AC_W: begin
					if (div_rsp.done) begin
						alpha_q <= div_rsp.quot;
						state_q <= S_VAL;
					end
				end
				S_VAL: begin
					neg_q   <= diff_neg;
					state_q <= S_VAL_W;
				end
				S_VAL_W: begin
					if (mul_rsp.done) begin
						value_q <= val_new;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= value_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule
